[sv/obcs_pkg.sv]
// Shared types, constants and elaboration-time functions for the oriented box block.
// Holds the per-degree sine generator and the angle folding helper.
// No dependencies.
`default_nettype none

package obcs_pkg;

    // Field widths
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned HEADING_W = 9;
    localparam int unsigned SPEED_W   = 10;
    localparam int unsigned SIZE_W    = 10;
    localparam int unsigned OUT_W     = 17;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 208;

    // Register indexes
    localparam logic [0:0] CFG_BOX_LEN = 1'b0;
    localparam logic [0:0] CFG_BOX_WID = 1'b1;

    // Angle constants in degrees
    localparam logic [HEADING_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEADING_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEADING_W-1:0] DEG_270 = 9'd270;
    localparam logic [HEADING_W-1:0] DEG_360 = 9'd360;

    // Number of entries in the quarter-wave table (0..90 degrees)
    localparam int unsigned QTAB_N = 91;
    localparam int unsigned QIDX_W = 7;

    // Series evaluation precision
    localparam int unsigned   SER_Q = 60;
    localparam logic [63:0]   PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0]   RAD_PER_DEG_Q60 = PI_Q60 / 64'd180;
    localparam int unsigned   SER_TERMS = 12;

    // Quarter-wave table selection: index into the table and sign to apply
    typedef struct packed {
        logic [QIDX_W-1:0] idx;
        logic              neg;
    } sin_sel_t;

    // Fold an angle in 0..359 onto the quarter-wave table
    function automatic sin_sel_t fold_angle(input logic [HEADING_W-1:0] a);
        sin_sel_t r;
        logic [HEADING_W-1:0] t;
        if (a <= DEG_90)
        begin
            t = a;
            r.neg = 1'b0;
        end
        else if (a <= DEG_180)
        begin
            t = DEG_180 - a;
            r.neg = 1'b0;
        end
        else if (a <= DEG_270)
        begin
            t = a - DEG_180;
            r.neg = 1'b1;
        end
        else
        begin
            t = DEG_360 - a;
            r.neg = 1'b1;
        end
        r.idx = t[QIDX_W-1:0];
        return r;
    endfunction

    // Fixed-point multiply with SER_Q fraction bits, kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[SER_Q+63:SER_Q];
    endfunction

    // Unsigned long division, one quotient bit per step from the top
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Series for sine or cosine of d degrees, d in 0..45, unsigned Q60
    function automatic logic [63:0] series_q60(input int unsigned d, input logic want_sin);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] k;
        x = 64'(d) * RAD_PER_DEG_Q60;
        x2 = mul_q60(x, x);
        term = want_sin ? x : (64'd1 << SER_Q);
        sum = term;
        k = want_sin ? 64'd1 : 64'd0;
        for (int n = 1; n <= SER_TERMS; n++)
        begin
            term = div_u64(mul_q60(term, x2), (k + 64'd1) * (k + 64'd2));
            k = k + 64'd2;
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // Sine of d degrees, d in 0..90, unsigned Q60
    function automatic logic [63:0] quarter_sin_q60(input int unsigned d);
        if (d <= 45)
            return series_q60(d, 1'b1);
        return series_q60(90 - d, 1'b0);
    endfunction

endpackage

`default_nettype wire

[sv/oriented_box_corners_and_step.sv]
// Throughput: one request per cycle while m_tready holds; each pipeline stage holds one
// request and refills as soon as its content moves on, so bubbles collapse under stalls.
// Reset: clears all stage valid bits and sets the box length and width registers to 0.
// Oriented box corners and forward/backward step, seven-stage pipeline.
// Depends on obcs_pkg for field widths, table generator and angle folding.
`default_nettype none

module oriented_box_corners_and_step #(
    parameter int SINE_FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [0:0]                          cfg_index,
    input  wire logic [obcs_pkg::SIZE_W-1:0]         cfg_data,
    // s_tdata, low bit up: center_x[16], center_y[16], heading_deg[9], speed[10], zero pad
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [obcs_pkg::IN_DATA_W-1:0]      s_tdata,
    // m_tdata, low bit up, 17 bits each: corner0_x, corner0_y, corner1_x, corner1_y,
    // corner2_x, corner2_y, corner3_x, corner3_y, ahead_x, ahead_y, behind_x,
    // behind_y, zero pad
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [obcs_pkg::OUT_DATA_W-1:0]          m_tdata
);
    import obcs_pkg::*;

    localparam int F    = SINE_FRAC_BITS;
    localparam int TW   = F + 2;          // signed sine/cosine
    localparam int PL_W = F + 13;         // size times sine
    localparam int PV_W = F + 12;         // speed times sine
    localparam int PS_W = F + 14;         // sum of two products
    localparam int PW   = F + 19;         // rounding argument width
    localparam int RW   = PW - F;         // rounded result width
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
    localparam int NSTG = 7;

    // round with F fraction bits, half away from zero
    function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + $signed(HALF) - $signed(PW'(p[PW-1]));
        return $signed(t[PW-1:F]);
    endfunction

    // Quarter-wave sine table, 0..90 degrees, rounded from Q60 half up
    logic [F:0] sin_tab [0:QTAB_N-1];
    for (genvar g = 0; g < QTAB_N; g++)
    begin : g_tab
        localparam logic [63:0] QV = quarter_sin_q60(g);
        localparam logic [63:0] RV = (QV + (64'd1 << (SER_Q - 1 - F))) >> (SER_Q - F);
        assign sin_tab[g] = RV[F:0];
    end

    // Configuration registers
    logic [SIZE_W-1:0] box_len_reg;
    logic [SIZE_W-1:0] box_wid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len_reg <= '0;
            box_wid_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_LEN: box_len_reg <= cfg_data;
                CFG_BOX_WID: box_wid_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] adv;

    always_comb
    begin
        adv[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int i = NSTG - 1; i >= 1; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[1])
                vld_reg[1] <= s_tvalid;
            for (int i = 2; i <= NSTG; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Stage 1: unpack, reduce heading, fold sine and cosine angles
    logic signed [COORD_W-1:0]   in_cx;
    logic signed [COORD_W-1:0]   in_cy;
    logic        [HEADING_W-1:0] in_hd;
    logic signed [SPEED_W-1:0]   in_sp;
    logic        [HEADING_W-1:0] deg;
    logic        [HEADING_W-1:0] deg_cos;

    assign in_cx = $signed(s_tdata[15:0]);
    assign in_cy = $signed(s_tdata[31:16]);
    assign in_hd = s_tdata[40:32];
    assign in_sp = $signed(s_tdata[50:41]);

    always_comb
    begin
        deg = (in_hd >= DEG_360) ? in_hd - DEG_360 : in_hd;
        deg_cos = deg + DEG_90;
        if (deg_cos >= DEG_360)
            deg_cos = deg_cos - DEG_360;
    end

    logic signed [COORD_W-1:0] cx1_reg, cy1_reg;
    logic signed [SPEED_W-1:0] sp1_reg;
    sin_sel_t                  ssel1_reg, csel1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            cx1_reg   <= in_cx;
            cy1_reg   <= in_cy;
            sp1_reg   <= in_sp;
            ssel1_reg <= fold_angle(deg);
            csel1_reg <= fold_angle(deg_cos);
        end
    end

    // Stage 2: table lookup and quadrant sign
    logic signed [TW-1:0] sin_mag, cos_mag;
    assign sin_mag = $signed({1'b0, sin_tab[ssel1_reg.idx]});
    assign cos_mag = $signed({1'b0, sin_tab[csel1_reg.idx]});

    logic signed [COORD_W-1:0] cx2_reg, cy2_reg;
    logic signed [SPEED_W-1:0] sp2_reg;
    logic signed [TW-1:0]      sin2_reg, cos2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            sp2_reg  <= sp1_reg;
            sin2_reg <= ssel1_reg.neg ? -sin_mag : sin_mag;
            cos2_reg <= csel1_reg.neg ? -cos_mag : cos_mag;
        end
    end

    // Stage 3: products of sizes and speed with sine and cosine
    logic signed [SIZE_W:0] len_s, wid_s;
    assign len_s = $signed({1'b0, box_len_reg});
    assign wid_s = $signed({1'b0, box_wid_reg});

    logic signed [COORD_W-1:0] cx3_reg, cy3_reg;
    logic signed [PL_W-1:0]    lc3_reg, ws3_reg, ls3_reg, wc3_reg;
    logic signed [PV_W-1:0]    vc3_reg, vs3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            lc3_reg <= PL_W'(len_s) * PL_W'(cos2_reg);
            ws3_reg <= PL_W'(wid_s) * PL_W'(sin2_reg);
            ls3_reg <= PL_W'(len_s) * PL_W'(sin2_reg);
            wc3_reg <= PL_W'(wid_s) * PL_W'(cos2_reg);
            vc3_reg <= PV_W'(sp2_reg) * PV_W'(cos2_reg);
            vs3_reg <= PV_W'(sp2_reg) * PV_W'(sin2_reg);
        end
    end

    // Stage 4: corner offset sums, round step offsets
    logic signed [COORD_W-1:0] cx4_reg, cy4_reg;
    logic signed [PS_W-1:0]    p0x4_reg, p0y4_reg;
    logic signed [PL_W-1:0]    lc4_reg, ls4_reg;
    logic signed [RW-1:0]      dx4_reg, dy4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            cx4_reg  <= cx3_reg;
            cy4_reg  <= cy3_reg;
            p0x4_reg <= PS_W'(lc3_reg) - PS_W'(ws3_reg);
            p0y4_reg <= PS_W'(ls3_reg) + PS_W'(wc3_reg);
            lc4_reg  <= lc3_reg;
            ls4_reg  <= ls3_reg;
            dx4_reg  <= rnd(PW'(vc3_reg));
            dy4_reg  <= rnd(PW'(vs3_reg));
        end
    end

    // Stage 5: corner 0 and the stepped centers
    logic signed [RW-1:0] c0x_full, c0y_full;
    logic signed [RW-1:0] ax_full, ay_full, bx_full, by_full;

    assign c0x_full = RW'(cx4_reg) + rnd(PW'(p0x4_reg));
    assign c0y_full = RW'(cy4_reg) + rnd(PW'(p0y4_reg));
    assign ax_full  = RW'(cx4_reg) + dx4_reg;
    assign ay_full  = RW'(cy4_reg) + dy4_reg;
    assign bx_full  = RW'(cx4_reg) - dx4_reg;
    assign by_full  = RW'(cy4_reg) - dy4_reg;

    logic signed [COORD_W-1:0] cx5_reg, cy5_reg;
    logic signed [PL_W-1:0]    lc5_reg, ls5_reg;
    logic signed [OUT_W-1:0]   c0x5_reg, c0y5_reg;
    logic        [OUT_W-1:0]   ax5_reg, ay5_reg, bx5_reg, by5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            cx5_reg  <= cx4_reg;
            cy5_reg  <= cy4_reg;
            lc5_reg  <= lc4_reg;
            ls5_reg  <= ls4_reg;
            c0x5_reg <= $signed(c0x_full[OUT_W-1:0]);
            c0y5_reg <= $signed(c0y_full[OUT_W-1:0]);
            ax5_reg  <= ax_full[OUT_W-1:0];
            ay5_reg  <= ay_full[OUT_W-1:0];
            bx5_reg  <= bx_full[OUT_W-1:0];
            by5_reg  <= by_full[OUT_W-1:0];
        end
    end

    // Stage 6: corner 1 from corner 0, corner 2 by mirroring
    logic signed [RW-1:0] c1x_full, c1y_full;
    logic signed [OUT_W:0] c2x_full, c2y_full;

    assign c1x_full = rnd((PW'(c0x5_reg) <<< F) - (PW'(lc5_reg) <<< 1));
    assign c1y_full = rnd((PW'(c0y5_reg) <<< F) - (PW'(ls5_reg) <<< 1));
    assign c2x_full = ((OUT_W+1)'(cx5_reg) <<< 1) - (OUT_W+1)'(c0x5_reg);
    assign c2y_full = ((OUT_W+1)'(cy5_reg) <<< 1) - (OUT_W+1)'(c0y5_reg);

    logic signed [COORD_W-1:0] cx6_reg, cy6_reg;
    logic        [OUT_W-1:0]   c0x6_reg, c0y6_reg, c2x6_reg, c2y6_reg;
    logic signed [OUT_W-1:0]   c1x6_reg, c1y6_reg;
    logic        [OUT_W-1:0]   ax6_reg, ay6_reg, bx6_reg, by6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            cx6_reg  <= cx5_reg;
            cy6_reg  <= cy5_reg;
            c0x6_reg <= c0x5_reg;
            c0y6_reg <= c0y5_reg;
            c1x6_reg <= $signed(c1x_full[OUT_W-1:0]);
            c1y6_reg <= $signed(c1y_full[OUT_W-1:0]);
            c2x6_reg <= c2x_full[OUT_W-1:0];
            c2y6_reg <= c2y_full[OUT_W-1:0];
            ax6_reg  <= ax5_reg;
            ay6_reg  <= ay5_reg;
            bx6_reg  <= bx5_reg;
            by6_reg  <= by5_reg;
        end
    end

    // Stage 7: corner 3 by mirroring, pack the result
    logic signed [OUT_W:0] c3x_full, c3y_full;
    assign c3x_full = ((OUT_W+1)'(cx6_reg) <<< 1) - (OUT_W+1)'(c1x6_reg);
    assign c3y_full = ((OUT_W+1)'(cy6_reg) <<< 1) - (OUT_W+1)'(c1y6_reg);

    logic [OUT_DATA_W-1:0] out7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            out7_reg <= {4'd0,
                         by6_reg, bx6_reg, ay6_reg, ax6_reg,
                         c3y_full[OUT_W-1:0], c3x_full[OUT_W-1:0],
                         c2y6_reg, c2x6_reg,
                         c1y6_reg, c1x6_reg,
                         c0y6_reg, c0x6_reg};
        end
    end

    assign m_tdata = out7_reg;

`ifndef ASSERT_OFF
    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[1])
        else $error("accepted request not held in stage 1");

    // back-pressure at the input only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg))
        else $error("input blocked with a free stage");

    // a stalled middle stage keeps its request
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !adv[4]) |=> vld_reg[3])
        else $error("stage 3 request dropped during stall");

    // looked-up sine and cosine stay within plus or minus one
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> ((sin2_reg <= $signed(TW'(1) <<< F)) &&
                        (sin2_reg >= -$signed(TW'(1) <<< F)) &&
                        (cos2_reg <= $signed(TW'(1) <<< F)) &&
                        (cos2_reg >= -$signed(TW'(1) <<< F))))
        else $error("sine or cosine out of range");
`endif

endmodule

`default_nettype wire
